// ----- sv/sgi_pkg.sv -----
package sgi_pkg;

	localparam int QW        = 63;
	localparam int DIV_STEPS = QW;
	localparam int MUL_STEPS = 4;

	localparam logic [QW-1:0] SMAX63 = {QW{1'b1}};
	localparam logic signed [65:0] SMAX66  = 66'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [65:0] NSMAX66 = 66'sh3_8000_0000_0000_0001;

	typedef enum logic [1:0] {
		KIND_PARALLEL, KIND_COINCIDENT, KIND_CROSSING, KIND_DEGENERATE
	} kind_t;

	typedef struct packed {
		logic signed [31:0] first_start_x;
		logic signed [31:0] first_start_y;
		logic signed [31:0] first_end_x;
		logic signed [31:0] first_end_y;
		logic signed [31:0] second_start_x;
		logic signed [31:0] second_start_y;
		logic signed [31:0] second_end_x;
		logic signed [31:0] second_end_y;
	} pair_t;

	typedef struct packed {
		logic [1:0]         relation_kind;
		logic               point_valid;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} result_t;

	typedef struct packed {
		logic [QW-1:0] rem;
		logic [QW-1:0] low;
		logic [QW-1:0] den;
	} div_in_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] from_mag(input logic neg, input logic [QW-1:0] m);
		logic signed [63:0] s;
		s = $signed({1'b0, m});
		return neg ? -s : s;
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
		logic signed [63:0] r;
		if (v > SMAX66) begin
			r = SMAX66[63:0];
		end else if (v < NSMAX66) begin
			r = NSMAX66[63:0];
		end else begin
			r = v[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/sgi_div.sv -----
module sgi_div (
	input  logic                 clk,
	input  logic                 en,
	input  sgi_pkg::div_in_t     lane,
	output logic [sgi_pkg::QW-1:0] quo
);

	typedef struct packed {
		logic [sgi_pkg::QW-1:0] rem;
		logic [sgi_pkg::QW-1:0] low;
		logic [sgi_pkg::QW-1:0] den;
		logic [sgi_pkg::QW-1:0] quo;
	} step_t;

	step_t st_s [sgi_pkg::DIV_STEPS];
	step_t first;

	function automatic step_t div_step(input step_t s);
		logic [sgi_pkg::QW:0] t;
		step_t r;
		t = {s.rem, s.low[sgi_pkg::QW-1]};
		r.den = s.den;
		r.low = {s.low[sgi_pkg::QW-2:0], 1'b0};
		if (t >= {1'b0, s.den}) begin
			r.rem = sgi_pkg::QW'(t - {1'b0, s.den});
			r.quo = {s.quo[sgi_pkg::QW-2:0], 1'b1};
		end else begin
			r.rem = t[sgi_pkg::QW-1:0];
			r.quo = {s.quo[sgi_pkg::QW-2:0], 1'b0};
		end
		return r;
	endfunction

	always_comb begin
		first.rem = lane.rem;
		first.low = lane.low;
		first.den = lane.den;
		first.quo = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= div_step(first);
			for (int i = 1; i < sgi_pkg::DIV_STEPS; i++) begin
				st_s[i] <= div_step(st_s[i-1]);
			end
		end
	end

	assign quo = st_s[sgi_pkg::DIV_STEPS-1].quo;

endmodule

// ----- sv/sgi_mulq.sv -----
module sgi_mulq (
	input  logic                   clk,
	input  logic                   en,
	input  logic [sgi_pkg::QW-1:0] a,
	input  logic [sgi_pkg::QW-1:0] b,
	output logic [sgi_pkg::QW-1:0] prod
);

	logic [63:0]  p00_s1, p01_s1;
	logic [30:0]  ahi_s1, bhi_s1;
	logic [31:0]  blo_s1;
	logic [63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic [64:0]  mid_s3;
	logic [125:0] cat_s3;
	logic [125:0] full;
	logic [sgi_pkg::QW-1:0] prod_s4;

	assign full = cat_s3 + {29'b0, mid_s3, 32'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= {32'b0, a[31:0]} * {32'b0, b[31:0]};
			p01_s1  <= {32'b0, a[31:0]} * {33'b0, b[62:32]};
			ahi_s1  <= a[62:32];
			bhi_s1  <= b[62:32];
			blo_s1  <= b[31:0];
			p00_s2  <= p00_s1;
			p01_s2  <= p01_s1;
			p10_s2  <= {33'b0, ahi_s1} * {32'b0, blo_s1};
			p11_s2  <= {33'b0, ahi_s1} * {33'b0, bhi_s1};
			mid_s3  <= {1'b0, p01_s2} + {1'b0, p10_s2};
			cat_s3  <= {p11_s2[61:0], p00_s2};
			prod_s4 <= (|full[125:79]) ? sgi_pkg::SMAX63 : full[78:16];
		end
	end

	assign prod = prod_s4;

endmodule

// ----- sv/segment_intersection_2d.sv -----
// Throughput: one item per cycle while the result is not stalled; the
// 63-step bit-per-stage dividers (slope, crossing x) and the 4-stage
// multipliers set the depth.
// A stalled result freezes the whole pipeline.
// Reset (arst_n, async, active low) clears all valid bits; data is not reset.
module segment_intersection_2d (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pair_valid,
	output logic             pair_stall,
	input  sgi_pkg::pair_t   pair,
	output logic             result_valid,
	input  logic             result_stall,
	output sgi_pkg::result_t result
);

	typedef enum logic [2:0] {X_ZERO, X_AX0, X_BX0, X_MIN4, X_DIV} xsrc_t;
	typedef enum logic [1:0] {Y_ZERO, Y_LINE, Y_AMIN} ysrc_t;

	typedef struct packed {
		sgi_pkg::pair_t     p;
		logic               va, vb, deg;
		logic               neg_ka, neg_kb, sat_ka, sat_kb;
		logic               neg_ia, neg_ib;
		logic               neg_x, sat_x, neg_y;
		sgi_pkg::kind_t     kind;
		xsrc_t              xsrc;
		ysrc_t              ysrc;
		logic signed [31:0] ax_min, ax_max, ay_min, ay_max;
		logic signed [31:0] bx_min, bx_max, by_min, by_max, x_min4;
		logic signed [63:0] ka, kb, ba, bb, n, d, px, bl, t, py;
	} ctx_t;

	localparam int DS = sgi_pkg::DIV_STEPS;
	localparam int MS = sgi_pkg::MUL_STEPS;

	logic en;

	sgi_pkg::pair_t   p_s1;
	ctx_t             ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9;
	ctx_t             c2, c3, c4, c5, c6, c7, c8, c9;
	sgi_pkg::div_in_t lane_a_s2, lane_b_s2, lane_x_s6, la2, lb2, lx6;
	ctx_t             dly1_s [DS];
	ctx_t             dly2_s [MS];
	ctx_t             dly3_s [DS];
	ctx_t             dly4_s [MS];
	logic [DS-1:0]    vd1_s, vd3_s;
	logic [MS-1:0]    vd2_s, vd4_s;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [sgi_pkg::QW-1:0] quo_a, quo_b, quo_x, prod_ia, prod_ib, prod_y;
	logic [sgi_pkg::QW-1:0] ia_x_s3, ia_k_s3, ib_x_s3, ib_k_s3, ly_k_s7, ly_x_s7;
	logic [sgi_pkg::QW-1:0] ia_x, ia_k, ib_x, ib_k, ly_k, ly_x;
	sgi_pkg::result_t res_s10, r10;

	function automatic logic signed [31:0] min32(input logic signed [31:0] a, b);
		return (a <= b) ? a : b;
	endfunction

	function automatic logic signed [31:0] max32(input logic signed [31:0] a, b);
		return (a >= b) ? a : b;
	endfunction

	assign en           = !(v_s10 && result_stall);
	assign pair_stall   = !en;
	assign result_valid = v_s10;
	assign result       = res_s10;

	// slopes
	always_comb begin
		logic signed [32:0] dxa, dya, dxb, dyb;
		logic [32:0] uxa, uya, uxb, uyb;
		dxa = 33'(p_s1.first_end_x) - 33'(p_s1.first_start_x);
		dya = 33'(p_s1.first_end_y) - 33'(p_s1.first_start_y);
		dxb = 33'(p_s1.second_end_x) - 33'(p_s1.second_start_x);
		dyb = 33'(p_s1.second_end_y) - 33'(p_s1.second_start_y);
		uxa = dxa[32] ? 33'(-dxa) : 33'(dxa);
		uya = dya[32] ? 33'(-dya) : 33'(dya);
		uxb = dxb[32] ? 33'(-dxb) : 33'(dxb);
		uyb = dyb[32] ? 33'(-dyb) : 33'(dyb);
		c2 = '0;
		c2.p = p_s1;
		c2.va = (dxa == 33'sd0);
		c2.vb = (dxb == 33'sd0);
		c2.deg = (c2.va && dya == 33'sd0) || (c2.vb && dyb == 33'sd0);
		c2.neg_ka = dya[32] ^ dxa[32];
		c2.neg_kb = dyb[32] ^ dxb[32];
		c2.sat_ka = ({31'b0, uya[32:31]} >= uxa);
		c2.sat_kb = ({31'b0, uyb[32:31]} >= uxb);
		c2.ax_min = min32(p_s1.first_start_x, p_s1.first_end_x);
		c2.ax_max = max32(p_s1.first_start_x, p_s1.first_end_x);
		c2.ay_min = min32(p_s1.first_start_y, p_s1.first_end_y);
		c2.ay_max = max32(p_s1.first_start_y, p_s1.first_end_y);
		c2.bx_min = min32(p_s1.second_start_x, p_s1.second_end_x);
		c2.bx_max = max32(p_s1.second_start_x, p_s1.second_end_x);
		c2.by_min = min32(p_s1.second_start_y, p_s1.second_end_y);
		c2.by_max = max32(p_s1.second_start_y, p_s1.second_end_y);
		la2.rem = {61'b0, uya[32:31]};
		la2.low = {uya[30:0], 32'b0};
		la2.den = {30'b0, uxa};
		lb2.rem = {61'b0, uyb[32:31]};
		lb2.low = {uyb[30:0], 32'b0};
		lb2.den = {30'b0, uxb};
	end

	sgi_div u_div_ka (.clk(clk), .en(en), .lane(lane_a_s2), .quo(quo_a));
	sgi_div u_div_kb (.clk(clk), .en(en), .lane(lane_b_s2), .quo(quo_b));

	// intercept products
	always_comb begin
		logic [63:0] mka, mkb;
		logic [31:0] mxa, mxb;
		c3 = dly1_s[DS-1];
		c3.ka = sgi_pkg::from_mag(c3.neg_ka, c3.sat_ka ? sgi_pkg::SMAX63 : quo_a);
		c3.kb = sgi_pkg::from_mag(c3.neg_kb, c3.sat_kb ? sgi_pkg::SMAX63 : quo_b);
		mka = sgi_pkg::mag64(c3.ka);
		mkb = sgi_pkg::mag64(c3.kb);
		mxa = c3.p.first_start_x[31] ? 32'(-c3.p.first_start_x) : 32'(c3.p.first_start_x);
		mxb = c3.p.second_start_x[31] ? 32'(-c3.p.second_start_x)
			: 32'(c3.p.second_start_x);
		c3.neg_ia = c3.p.first_start_x[31] ^ c3.ka[63];
		c3.neg_ib = c3.p.second_start_x[31] ^ c3.kb[63];
		ia_x = {31'b0, mxa};
		ib_x = {31'b0, mxb};
		ia_k = mka[62:0];
		ib_k = mkb[62:0];
	end

	sgi_mulq u_mul_ia (.clk(clk), .en(en), .a(ia_x_s3), .b(ia_k_s3), .prod(prod_ia));
	sgi_mulq u_mul_ib (.clk(clk), .en(en), .a(ib_x_s3), .b(ib_k_s3), .prod(prod_ib));

	// intercepts
	always_comb begin
		logic signed [63:0] mna, mnb;
		c4 = dly2_s[MS-1];
		mna = sgi_pkg::from_mag(c4.neg_ia, prod_ia);
		mnb = sgi_pkg::from_mag(c4.neg_ib, prod_ib);
		c4.ba = sgi_pkg::sat64((66'(c4.p.first_start_y) <<< 16) - 66'(mna));
		c4.bb = sgi_pkg::sat64((66'(c4.p.second_start_y) <<< 16) - 66'(mnb));
	end

	// classify
	always_comb begin
		logic eqk, eqb;
		c5 = ctx_s4;
		c5.n = sgi_pkg::sat64(66'(c5.bb) - 66'(c5.ba));
		c5.d = sgi_pkg::sat64(66'(c5.ka) - 66'(c5.kb));
		c5.x_min4 = min32(c5.ax_min, c5.bx_min);
		eqk = (c5.ka == c5.kb);
		eqb = (c5.ba == c5.bb);
		c5.kind = sgi_pkg::KIND_PARALLEL;
		c5.xsrc = X_ZERO;
		c5.ysrc = Y_ZERO;
		if (c5.deg) begin
			c5.kind = sgi_pkg::KIND_DEGENERATE;
		end else if (c5.va && c5.vb) begin
			if (c5.p.first_start_x == c5.p.second_start_x) begin
				c5.kind = sgi_pkg::KIND_COINCIDENT;
				c5.xsrc = X_AX0;
				c5.ysrc = Y_AMIN;
			end
		end else if (c5.va) begin
			c5.kind = sgi_pkg::KIND_CROSSING;
			c5.xsrc = X_AX0;
			c5.ysrc = Y_LINE;
		end else if (c5.vb) begin
			c5.kind = sgi_pkg::KIND_CROSSING;
			c5.xsrc = X_BX0;
			c5.ysrc = Y_LINE;
		end else if (eqk) begin
			if (eqb) begin
				c5.kind = sgi_pkg::KIND_COINCIDENT;
				c5.xsrc = X_MIN4;
				c5.ysrc = Y_LINE;
			end
		end else begin
			c5.kind = sgi_pkg::KIND_CROSSING;
			c5.xsrc = eqb ? X_ZERO : X_DIV;
			c5.ysrc = Y_LINE;
		end
	end

	// crossing x divider setup
	always_comb begin
		logic [63:0] un, ud;
		c6 = ctx_s5;
		un = sgi_pkg::mag64(c6.n);
		ud = sgi_pkg::mag64(c6.d);
		c6.neg_x = c6.n[63] ^ c6.d[63];
		c6.sat_x = ({47'b0, un[62:47]} >= ud[62:0]);
		lx6.rem = {47'b0, un[62:47]};
		lx6.low = {un[46:0], 16'b0};
		lx6.den = ud[62:0];
	end

	sgi_div u_div_x (.clk(clk), .en(en), .lane(lane_x_s6), .quo(quo_x));

	// point x and line product operands
	always_comb begin
		logic signed [63:0] pxd, ksel;
		logic [63:0] mk, mx;
		c7 = dly3_s[DS-1];
		pxd = sgi_pkg::from_mag(c7.neg_x, c7.sat_x ? sgi_pkg::SMAX63 : quo_x);
		case (c7.xsrc)
			X_AX0:   c7.px = 64'(c7.p.first_start_x);
			X_BX0:   c7.px = 64'(c7.p.second_start_x);
			X_MIN4:  c7.px = 64'(c7.x_min4);
			X_DIV:   c7.px = pxd;
			default: c7.px = '0;
		endcase
		ksel = c7.va ? c7.kb : c7.ka;
		c7.bl = c7.va ? c7.bb : c7.ba;
		c7.neg_y = ksel[63] ^ c7.px[63];
		mk = sgi_pkg::mag64(ksel);
		mx = sgi_pkg::mag64(c7.px);
		ly_k = mk[62:0];
		ly_x = mx[62:0];
	end

	sgi_mulq u_mul_y (.clk(clk), .en(en), .a(ly_k_s7), .b(ly_x_s7), .prod(prod_y));

	always_comb begin
		logic signed [63:0] mn;
		c8 = dly4_s[MS-1];
		mn = sgi_pkg::from_mag(c8.neg_y, prod_y);
		c8.t = sgi_pkg::sat64(66'(c8.bl) + 66'(mn));
	end

	// point y, truncated toward zero
	always_comb begin
		logic signed [63:0] tq;
		c9 = ctx_s8;
		tq = c9.t[63] ? ((c9.t + 64'sd65535) >>> 16) : (c9.t >>> 16);
		case (c9.ysrc)
			Y_LINE:  c9.py = tq;
			Y_AMIN:  c9.py = 64'(c9.ay_min);
			default: c9.py = '0;
		endcase
	end

	// range checks and output saturation
	always_comb begin
		logic in_a, in_b;
		if (ctx_s9.va) begin
			in_a = (ctx_s9.py <= ctx_s9.ay_max) && (ctx_s9.py >= ctx_s9.ay_min);
		end else begin
			in_a = (ctx_s9.px <= ctx_s9.ax_max) && (ctx_s9.px >= ctx_s9.ax_min);
		end
		if (ctx_s9.vb) begin
			in_b = (ctx_s9.py <= ctx_s9.by_max) && (ctx_s9.py >= ctx_s9.by_min);
		end else begin
			in_b = (ctx_s9.px <= ctx_s9.bx_max) && (ctx_s9.px >= ctx_s9.bx_min);
		end
		r10.relation_kind = ctx_s9.kind;
		r10.point_valid = ((ctx_s9.kind == sgi_pkg::KIND_CROSSING)
			|| (ctx_s9.kind == sgi_pkg::KIND_COINCIDENT)) && in_a && in_b;
		r10.point_x = sgi_pkg::sat32(ctx_s9.px);
		r10.point_y = sgi_pkg::sat32(ctx_s9.py);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			vd1_s <= '0;
			v_s3  <= 1'b0;
			vd2_s <= '0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			vd3_s <= '0;
			v_s7  <= 1'b0;
			vd4_s <= '0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= pair_valid;
			v_s2  <= v_s1;
			vd1_s <= {vd1_s[DS-2:0], v_s2};
			v_s3  <= vd1_s[DS-1];
			vd2_s <= {vd2_s[MS-2:0], v_s3};
			v_s4  <= vd2_s[MS-1];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			vd3_s <= {vd3_s[DS-2:0], v_s6};
			v_s7  <= vd3_s[DS-1];
			vd4_s <= {vd4_s[MS-2:0], v_s7};
			v_s8  <= vd4_s[MS-1];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1      <= pair;
			ctx_s2    <= c2;
			lane_a_s2 <= la2;
			lane_b_s2 <= lb2;
			dly1_s[0] <= ctx_s2;
			for (int i = 1; i < DS; i++) begin
				dly1_s[i] <= dly1_s[i-1];
			end
			ctx_s3    <= c3;
			ia_x_s3   <= ia_x;
			ia_k_s3   <= ia_k;
			ib_x_s3   <= ib_x;
			ib_k_s3   <= ib_k;
			dly2_s[0] <= ctx_s3;
			for (int i = 1; i < MS; i++) begin
				dly2_s[i] <= dly2_s[i-1];
			end
			ctx_s4    <= c4;
			ctx_s5    <= c5;
			ctx_s6    <= c6;
			lane_x_s6 <= lx6;
			dly3_s[0] <= ctx_s6;
			for (int i = 1; i < DS; i++) begin
				dly3_s[i] <= dly3_s[i-1];
			end
			ctx_s7    <= c7;
			ly_k_s7   <= ly_k;
			ly_x_s7   <= ly_x;
			dly4_s[0] <= ctx_s7;
			for (int i = 1; i < MS; i++) begin
				dly4_s[i] <= dly4_s[i-1];
			end
			ctx_s8    <= c8;
			ctx_s9    <= c9;
			res_s10   <= r10;
		end
	end

endmodule
